// ----- src/dpr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpr_pkg
// Types and codes shared by the datagram port router and its checker.
// ----------------------------------------------------------------------------
package dpr_pkg;

	// number of ends; the end index fields below are sized for it
	localparam int END_COUNT = 8;

	// command codes
	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_RECV    = 2'd1;
	localparam logic [1:0] CMD_CLOSE   = 2'd2;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// destination kinds
	localparam logic [1:0] DK_UNICAST   = 2'd0;
	localparam logic [1:0] DK_BROADCAST = 2'd1;
	localparam logic [1:0] DK_INVALID   = 2'd2;
	localparam logic [1:0] DK_UNKNOWN   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_CLOSED   = 3'd3;
	localparam logic [2:0] ST_TOOLARGE = 3'd4;
	localparam logic [2:0] ST_UNREACH  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_DATAGRAM = 2'd0;
	localparam logic [1:0] REG_BYTE_BUDGET  = 2'd1;
	localparam logic [1:0] REG_BCAST_EN     = 2'd2;
	localparam logic [1:0] REG_ACTIVE_ENDS  = 2'd3;

	// byte arithmetic unit operations
	localparam logic ALU_ADD_CHECK = 1'b0;
	localparam logic ALU_SUB_SAT   = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  end_index;
		logic [1:0]  dest_kind;
		logic [15:0] dest_port;
		logic [15:0] length;
	} dpr_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  from_end;
		logic [15:0] rx_length;
		logic        end_open;
	} dpr_result_t;

	typedef struct packed {
		logic [2:0]  from_end;
		logic [15:0] rx_length;
	} dpr_desc_t;

endpackage

// ----- src/dpr_alu.sv -----
// ----------------------------------------------------------------------------
// dpr_alu
// Shared byte-count unit: budget check on add, saturating subtract on pop.
// ----------------------------------------------------------------------------
module dpr_alu import dpr_pkg::*; (
	input  logic        op,
	input  logic [20:0] a,
	input  logic [15:0] b,
	input  logic [19:0] budget,
	output logic [20:0] res,
	output logic        over
);

	logic [21:0] sum;

	always_comb begin
		sum  = {1'b0, a} + {6'd0, b};
		over = sum > {2'd0, budget};
		if (op == ALU_SUB_SAT) begin
			res = (a >= {5'd0, b}) ? (a - {5'd0, b}) : '0;
		end else begin
			res = sum[20:0];
		end
	end

endmodule

// ----- src/dpr_desc_ram.sv -----
// ----------------------------------------------------------------------------
// dpr_desc_ram
// Descriptor store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dpr_desc_ram import dpr_pkg::*; #(
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  dpr_desc_t     wdata,
	input  logic [AW-1:0] raddr,
	output dpr_desc_t     rdata
);

	dpr_desc_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/datagram_port_router.sv -----
// ----------------------------------------------------------------------------
// datagram_port_router
// Routes datagram descriptors between ends, each with its own receive queue.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  command   | start, busy (beat: start  | cmd (dpr_cmd_t)
//            | high while busy low)      |
//  result    | done, one-cycle strobe    | result (dpr_result_t)
//  config    | cfg_we                    | cfg_index, cfg_wdata
//
//  From accepted beat to strobe: close, rejects and unknown commands end in
//  S_DECIDE; unicast send passes S_DELIV; receive passes S_POP (registered
//  descriptor read); broadcast walks each existing end in S_BCAST, one queue per
//  cycle via the shared byte-count unit. A new beat is taken in the strobe cycle.
//  Reset: all ends attached, all queues empty, registers at their defaults.
//  The descriptor store is not cleared; only written entries are ever popped.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module datagram_port_router import dpr_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        start,
	input  dpr_cmd_t    cmd,
	output logic        busy,
	output logic        done,
	output dpr_result_t result
);

	localparam int EW = (END_COUNT > 1) ? $clog2(END_COUNT) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(END_COUNT + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_DELIV  = 3'd2;
	localparam logic [2:0] S_BCAST  = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;

	// configuration
	logic [15:0] max_q;
	logic [19:0] budget_q;
	logic        bcast_q;
	logic [3:0]  act_q;

	// per-end queue state
	logic          attached_q [END_COUNT];
	logic [20:0]   qbytes_q   [END_COUNT];
	logic [QW-1:0] head_q     [END_COUNT];
	logic [CW-1:0] count_q    [END_COUNT];

	// sequencer
	logic [2:0]    state_q;
	dpr_cmd_t      cmd_q;
	logic [EW-1:0] tgt_q;
	logic          done_q;
	dpr_result_t   res_q;

	logic [NW-1:0] n_ends;
	logic          self_ok;
	logic [EW-1:0] self_ix;
	logic          t_att;
	logic          t_can;
	logic          visit;
	logic          bcast_last;
	logic [CW:0]   tail_sum;
	logic [QW-1:0] tail;
	logic [QW-1:0] head_next;

	logic          alu_op;
	logic [20:0]   alu_a;
	logic [15:0]   alu_b;
	logic [20:0]   alu_res;
	logic          alu_over;

	logic           mem_we;
	dpr_desc_t      mem_wdata;
	dpr_desc_t      mem_rdata;
	logic [EW+QW-1:0] mem_waddr;
	logic [EW+QW-1:0] mem_raddr;

	// saturate the number of ends and check the issuing end exists
	always_comb begin
		n_ends  = ({28'd0, act_q} > 32'(END_COUNT)) ? NW'(END_COUNT) : NW'(act_q);
		self_ok = 32'(cmd_q.end_index) < 32'(n_ends);
		self_ix = EW'(cmd_q.end_index);
	end

	// share one byte-count unit between delivery and pop
	always_comb begin
		alu_op = (state_q == S_POP) ? ALU_SUB_SAT : ALU_ADD_CHECK;
		alu_a  = (state_q == S_POP) ? qbytes_q[self_ix] : qbytes_q[tgt_q];
		alu_b  = (state_q == S_POP) ? mem_rdata.rx_length : cmd_q.length;
	end

	dpr_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.budget (budget_q),
		.res    (alu_res),
		.over   (alu_over)
	);

	// delivery into the current target queue
	always_comb begin
		t_att      = attached_q[tgt_q];
		t_can      = !alu_over && (count_q[tgt_q] < CW'(QUEUE_DEPTH));
		visit      = (state_q == S_DELIV) || (tgt_q != self_ix);
		bcast_last = 32'(tgt_q) == (32'(n_ends) - 32'd1);
		tail_sum   = {1'b0, CW'(head_q[tgt_q])} + {1'b0, count_q[tgt_q]};
		if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
			tail = QW'(tail_sum - (CW+1)'(QUEUE_DEPTH));
		end else begin
			tail = QW'(tail_sum);
		end
		head_next = (32'(head_q[self_ix]) + 32'd1 == 32'(QUEUE_DEPTH)) ?
			'0 : head_q[self_ix] + QW'(1);
		mem_we = ((state_q == S_DELIV) || (state_q == S_BCAST)) && visit && t_att && t_can;
		mem_waddr = {tgt_q, tail};
		mem_wdata.from_end  = cmd_q.end_index;
		mem_wdata.rx_length = cmd_q.length;
		mem_raddr = {self_ix, head_q[self_ix]};
	end

	dpr_desc_ram #(.AW(EW + QW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= 16'd1200;
			budget_q <= 20'd65536;
			bcast_q  <= 1'b0;
			act_q    <= 4'd8;
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			tgt_q    <= '0;
			res_q    <= '0;
			for (int i = 0; i < END_COUNT; i++) begin
				attached_q[i] <= 1'b1;
				qbytes_q[i]   <= '0;
				head_q[i]     <= '0;
				count_q[i]    <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_DATAGRAM: max_q    <= cfg_wdata[15:0];
					REG_BYTE_BUDGET:  budget_q <= cfg_wdata;
					REG_BCAST_EN:     bcast_q  <= cfg_wdata[0];
					REG_ACTIVE_ENDS:  act_q    <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// default: finish now with an empty receive part
					res_q.from_end  <= '0;
					res_q.rx_length <= '0;
					res_q.end_open  <= attached_q[self_ix];
					res_q.status    <= ST_OK;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (!self_ok) begin
						res_q.end_open <= 1'b0;
						if (cmd_q.command != CMD_UNKNOWN) begin
							res_q.status <= ST_CLOSED;
						end
					end else begin
						case (cmd_q.command)
							CMD_SEND: begin
								if (!attached_q[self_ix]) begin
									res_q.status <= ST_CLOSED;
								end else if (cmd_q.length > max_q) begin
									res_q.status <= ST_TOOLARGE;
								end else if (cmd_q.dest_kind == DK_BROADCAST) begin
									if (!bcast_q) begin
										res_q.status <= ST_UNREACH;
									end else begin
										// walk every end from zero
										tgt_q   <= '0;
										done_q  <= 1'b0;
										state_q <= S_BCAST;
									end
								end else if (cmd_q.dest_kind != DK_UNICAST) begin
									res_q.status <= ST_UNREACH;
								end else if (cmd_q.dest_port == 16'd0 ||
									32'(cmd_q.dest_port) > 32'(n_ends)) begin
									res_q.status <= ST_OK;
								end else begin
									tgt_q   <= EW'(cmd_q.dest_port - 16'd1);
									done_q  <= 1'b0;
									state_q <= S_DELIV;
								end
							end
							CMD_RECV: begin
								if (!attached_q[self_ix]) begin
									res_q.status <= ST_CLOSED;
								end else if (count_q[self_ix] == '0) begin
									res_q.status <= ST_EMPTY;
								end else begin
									// head descriptor read is in flight
									done_q  <= 1'b0;
									state_q <= S_POP;
								end
							end
							CMD_CLOSE: begin
								// detach and flush
								attached_q[self_ix] <= 1'b0;
								count_q[self_ix]    <= '0;
								head_q[self_ix]     <= '0;
								qbytes_q[self_ix]   <= '0;
								res_q.end_open      <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_DELIV, S_BCAST: begin
					if (mem_we) begin
						count_q[tgt_q]  <= count_q[tgt_q] + CW'(1);
						qbytes_q[tgt_q] <= alu_res;
					end
					if (state_q == S_DELIV || bcast_last) begin
						res_q.status <= (state_q == S_DELIV && t_att && !t_can) ?
							ST_FULL : ST_OK;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						tgt_q <= tgt_q + EW'(1);
					end
				end
				S_POP: begin
					qbytes_q[self_ix] <= alu_res;
					head_q[self_ix]   <= head_next;
					count_q[self_ix]  <= count_q[self_ix] - CW'(1);
					res_q.status      <= ST_OK;
					res_q.from_end    <= mem_rdata.from_end;
					res_q.rx_length   <= mem_rdata.rx_length;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the command beat for the whole operation
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/dpr_checker.sv -----
// ----------------------------------------------------------------------------
// dpr_checker
// Port-level checks on the datagram port router, bound to the top level.
// ----------------------------------------------------------------------------
module dpr_checker import dpr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input dpr_result_t result
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted beat");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_UNREACH)
		else $error("status code out of range");

	a_rx_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.from_end == '0 && result.rx_length == '0)
		else $error("receive fields set on a failed command");

	a_closed_not_open: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_CLOSED |-> !result.end_open)
		else $error("closed status with end still open");

endmodule

bind datagram_port_router dpr_checker u_dpr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
